>>> hw/rtl/x86d_pkg.sv
// Shared types, codes and opcode table for the x86-64 subset decoder.
// No dependencies.
package x86d_pkg;

    // Operand spec codes from the opcode table
    typedef enum logic [3:0] {
        S_NONE = 4'd0, S_EB = 4'd1, S_EV = 4'd2, S_GB = 4'd3, S_GV = 4'd4,
        S_IB = 4'd5, S_IV = 4'd6, S_IZ = 4'd7, S_M = 4'd8, S_JB = 4'd9,
        S_JZ = 4'd10, S_R8 = 4'd11, S_R64 = 4'd12, S_RAL = 4'd13
    } spec_t;

    typedef enum logic [1:0] {
        G_NONE = 2'd0, G_ONE = 2'd1, G_THREE = 2'd3
    } grp_t;

    localparam logic [4:0] MN_ADD = 5'd0, MN_SBB = 5'd3, MN_AND = 5'd4,
        MN_XOR = 5'd6, MN_TEST = 5'd8, MN_PUSH = 5'd15, MN_POP = 5'd16,
        MN_JE = 5'd17, MN_JNE = 5'd18, MN_MOV = 5'd19, MN_LEA = 5'd20,
        MN_RET = 5'd21, MN_INT3 = 5'd22, MN_CALL = 5'd23, MN_JMP = 5'd24;

    localparam logic [1:0] ST_OK = 2'd0, ST_UNKNOWN = 2'd1, ST_UNSUP = 2'd2;

    localparam logic [2:0] K_NONE = 3'd0, K_REG8 = 3'd1, K_REG8X = 3'd2,
        K_REG32 = 3'd3, K_REG64 = 3'd4, K_REL = 3'd5, K_IMM = 3'd6, K_MEM = 3'd7;

    typedef struct packed {
        logic       known;
        grp_t       grp;
        logic [4:0] mn;
        spec_t      a;
        spec_t      b;
    } opinfo_t;

    // Resolved opcode info (group resolved by the ModR/M reg field)
    typedef struct packed {
        logic       ok;
        logic [4:0] mn;
        spec_t      a;
        spec_t      b;
    } resinfo_t;

    function automatic opinfo_t base_info(input logic [7:0] op);
        opinfo_t r;
        r = '{known: 1'b1, grp: G_NONE, mn: 5'd0, a: S_NONE, b: S_NONE};
        if (op[7:3] == 5'b01010) begin r.mn = MN_PUSH; r.a = S_R64; end
        else if (op[7:3] == 5'b01011) begin r.mn = MN_POP; r.a = S_R64; end
        else if (op[7:3] == 5'b10110) begin r.mn = MN_MOV; r.a = S_R8; r.b = S_IB; end
        else if (op[7:3] == 5'b10111) begin r.mn = MN_MOV; r.a = S_R64; r.b = S_IV; end
        else begin
            case (op)
                8'h03: begin r.mn = MN_ADD; r.a = S_GV; r.b = S_EV; end
                8'h1b: begin r.mn = MN_SBB; r.a = S_GV; r.b = S_EV; end
                8'h24: begin r.mn = MN_AND; r.a = S_RAL; r.b = S_IB; end
                8'h33: begin r.mn = MN_XOR; r.a = S_GV; r.b = S_EV; end
                8'h74: begin r.mn = MN_JE; r.a = S_JB; end
                8'h75: begin r.mn = MN_JNE; r.a = S_JB; end
                8'h80: begin r.grp = G_ONE; r.a = S_EB; r.b = S_IB; end
                8'h81: begin r.grp = G_ONE; r.a = S_EV; r.b = S_IZ; end
                8'h83: begin r.grp = G_ONE; r.a = S_EV; r.b = S_IB; end
                8'h84: begin r.mn = MN_TEST; r.a = S_EB; r.b = S_GB; end
                8'h85: begin r.mn = MN_TEST; r.a = S_EV; r.b = S_GV; end
                8'h89: begin r.mn = MN_MOV; r.a = S_EV; r.b = S_GV; end
                8'h8b: begin r.mn = MN_MOV; r.a = S_GV; r.b = S_EV; end
                8'h8d: begin r.mn = MN_LEA; r.a = S_GV; r.b = S_M; end
                8'hc3: r.mn = MN_RET;
                8'hcc: r.mn = MN_INT3;
                8'he8: begin r.mn = MN_CALL; r.a = S_JZ; end
                8'he9: begin r.mn = MN_JMP; r.a = S_JZ; end
                8'heb: begin r.mn = MN_JMP; r.a = S_JB; end
                8'hf6: begin r.grp = G_THREE; r.a = S_EB; end
                8'hf7: begin r.grp = G_THREE; r.a = S_EV; end
                default: r.known = 1'b0;
            endcase
        end
        return r;
    endfunction

    function automatic resinfo_t resolve(input logic [7:0] op, input logic [2:0] reg_f);
        opinfo_t  bi;
        resinfo_t r;
        bi = base_info(op);
        r = '{ok: bi.known, mn: bi.mn, a: bi.a, b: bi.b};
        case (bi.grp)
            G_ONE: r.mn = {2'b00, reg_f};
            G_THREE:
            begin
                if (reg_f == 3'd1) r.ok = 1'b0;
                else if (reg_f == 3'd0)
                begin
                    r.mn = MN_TEST;
                    r.b = (op == 8'hf6) ? S_IB : S_IZ;
                end
                else r.mn = 5'd7 + {2'b00, reg_f};
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] imm_len(input spec_t s);
        case (s)
            S_IB, S_JB: return 3'd1;
            S_IV, S_IZ, S_JZ: return 3'd4;
            default: return 3'd0;
        endcase
    endfunction

    function automatic logic is_modrm(input spec_t s);
        return s == S_EB || s == S_EV || s == S_GB || s == S_GV || s == S_M;
    endfunction

endpackage

>>> hw/rtl/x86d_operand.sv
// Operand formatter: turns one operand spec plus held decode state into kind/reg.
// Depends on x86d_pkg.
module x86d_operand (
    input  x86d_pkg::spec_t s,
    input  logic [7:0]      opcode,
    input  logic [7:0]      modrm,
    input  logic [4:0]      rex,
    input  logic [3:0]      mem_base,
    output logic [2:0]      kind,
    output logic [3:0]      rnum
);
    import x86d_pkg::*;

    logic       rexp;
    logic       w;
    logic [1:0] md;

    assign rexp = rex[4];
    assign w    = rex[3];
    assign md   = modrm[7:6];

    // Kind and register by spec
    always_comb
    begin
        kind = K_NONE;
        rnum = 4'd0;
        case (s)
            S_EB, S_EV, S_M:
            begin
                if (md == 2'd3)
                begin
                    rnum = {rex[0], modrm[2:0]};
                    kind = (s == S_EV) ? (w ? K_REG64 : K_REG32) : (rexp ? K_REG8X : K_REG8);
                end
                else
                begin
                    kind = K_MEM;
                    rnum = mem_base;
                end
            end
            S_GB: begin kind = rexp ? K_REG8X : K_REG8; rnum = {rex[2], modrm[5:3]}; end
            S_GV: begin kind = w ? K_REG64 : K_REG32; rnum = {rex[2], modrm[5:3]}; end
            S_IB, S_IV, S_IZ: kind = K_IMM;
            S_JB, S_JZ: kind = K_REL;
            S_R8: begin kind = rexp ? K_REG8X : K_REG8; rnum = {rex[0], opcode[2:0]}; end
            S_R64: begin kind = K_REG64; rnum = {rex[0], opcode[2:0]}; end
            S_RAL: kind = K_REG8;
            default: ;
        endcase
    end
endmodule

>>> hw/rtl/x86_64_subset_instruction_decoder.sv
// Top level of the byte-serial x86-64 subset decoder: parse state machine and result register.
// Depends on x86d_pkg and x86d_operand.
//
//   channel  | handshake            | word
//   in       | in_valid / in_stall  | code_byte
//   out      | out_valid / out_stall| decoded instruction fields
//
// One code byte per cycle while in_stall is low; a result appears in the output register
// the cycle after its last byte. The parse step is one level of table lookup between the
// state registers and the output register. Reset clears the parser to expect a prefix or
// opcode. Input is stalled whenever a result waits in the output register and out_stall
// is high.
module x86_64_subset_instruction_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  code_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  opcode_byte,
    output logic [4:0]  mnemonic,
    output logic [3:0]  length,
    output logic [2:0]  first_kind,
    output logic [3:0]  first_reg,
    output logic [2:0]  second_kind,
    output logic [3:0]  second_reg,
    output logic [1:0]  disp_size,
    output logic signed [31:0] disp_value,
    output logic [31:0] imm_value,
    output logic [1:0]  status
);
    import x86d_pkg::*;

    typedef enum logic [2:0] {
        PH_START, PH_OPC, PH_MODRM, PH_SIB, PH_DISP, PH_IMM
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  rex_reg, rex_next;
    logic [7:0]  op_reg, op_next;
    logic [7:0]  mrm_reg, mrm_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [1:0]  fidx_reg, fidx_next;
    logic [31:0] disp_reg, disp_next;
    logic [31:0] imm_reg, imm_next;
    logic [3:0]  base_reg, base_next;

    logic        emit;
    logic [1:0]  st;
    logic        ov_reg;

    logic        accept;
    logic [3:0]  cnt_inc;
    opinfo_t     bi;
    resinfo_t    ri;
    logic        fin;
    logic [2:0]  need;
    logic [2:0]  n;
    logic [31:0] shifted;

    assign accept   = in_valid && !in_stall;
    assign in_stall = ov_reg && out_stall;
    assign cnt_inc  = cnt_reg + 4'd1;
    assign bi       = base_info(code_byte);
    assign n        = {1'b0, fidx_reg} + 3'd1;
    assign shifted  = {24'd0, code_byte} << {fidx_reg, 3'b000};

    // Next-state parse logic; the "finish" values are taken from *_next
    always_comb
    begin
        phase_next = phase_reg;
        rex_next   = rex_reg;
        op_next    = op_reg;
        mrm_next   = mrm_reg;
        cnt_next   = cnt_reg;
        fidx_next  = fidx_reg;
        disp_next  = disp_reg;
        imm_next   = imm_reg;
        base_next  = base_reg;
        emit       = 1'b0;
        st         = ST_OK;
        fin        = 1'b0;
        ri         = resolve(op_reg, mrm_reg[5:3]);
        need       = 3'd0;
        case (phase_reg)
            PH_START, PH_OPC:
            begin
                if (phase_reg == PH_START && code_byte[7:4] == 4'h4)
                begin
                    rex_next   = {1'b1, code_byte[3:0]};
                    cnt_next   = 4'd1;
                    phase_next = PH_OPC;
                end
                else
                begin
                    op_next  = code_byte;
                    cnt_next = cnt_inc;
                    ri = resolve(code_byte, mrm_reg[5:3]);
                    if (!bi.known) begin emit = 1'b1; st = ST_UNKNOWN; end
                    else if ((bi.a == S_R8 || bi.a == S_R64) && rex_reg[3:1] != 3'd0)
                    begin emit = 1'b1; st = ST_UNSUP; end
                    else if (bi.b == S_IV && rex_reg != 5'd0)
                    begin emit = 1'b1; st = ST_UNSUP; end
                    else if (is_modrm(bi.a) || is_modrm(bi.b)) phase_next = PH_MODRM;
                    else if (!ri.ok) begin emit = 1'b1; st = ST_UNKNOWN; end
                    else if (imm_len(ri.a) + imm_len(ri.b) != 3'd0)
                    begin phase_next = PH_IMM; fidx_next = 2'd0; end
                    else fin = 1'b1;
                end
            end
            PH_MODRM:
            begin
                mrm_next = code_byte;
                cnt_next = cnt_inc;
                ri = resolve(op_reg, code_byte[5:3]);
                if (!ri.ok) begin emit = 1'b1; st = ST_UNKNOWN; end
                else if (code_byte[7:6] == 2'd3)
                begin
                    if (ri.a == S_M || ri.b == S_M) begin emit = 1'b1; st = ST_UNSUP; end
                    else if (imm_len(ri.a) + imm_len(ri.b) != 3'd0)
                    begin phase_next = PH_IMM; fidx_next = 2'd0; end
                    else fin = 1'b1;
                end
                else if (code_byte[2:0] == 3'd4) phase_next = PH_SIB;
                else
                begin
                    base_next = {rex_reg[0], code_byte[2:0]};
                    if (code_byte[7:6] != 2'd0) begin phase_next = PH_DISP; fidx_next = 2'd0; end
                    else if (imm_len(ri.a) + imm_len(ri.b) != 3'd0)
                    begin phase_next = PH_IMM; fidx_next = 2'd0; end
                    else fin = 1'b1;
                end
            end
            PH_SIB:
            begin
                cnt_next = cnt_inc;
                if (code_byte[5:3] != 3'd4) begin emit = 1'b1; st = ST_UNSUP; end
                else
                begin
                    base_next = {rex_reg[0], code_byte[2:0]};
                    if (mrm_reg[7:6] == 2'd1 || mrm_reg[7:6] == 2'd2)
                    begin phase_next = PH_DISP; fidx_next = 2'd0; end
                    else if (!ri.ok) begin emit = 1'b1; st = ST_UNKNOWN; end
                    else if (imm_len(ri.a) + imm_len(ri.b) != 3'd0)
                    begin phase_next = PH_IMM; fidx_next = 2'd0; end
                    else fin = 1'b1;
                end
            end
            PH_DISP:
            begin
                need      = (mrm_reg[7:6] == 2'd1) ? 3'd1 : 3'd4;
                disp_next = disp_reg | shifted;
                cnt_next  = cnt_inc;
                if (n >= need)
                begin
                    if (!ri.ok) begin emit = 1'b1; st = ST_UNKNOWN; end
                    else if (imm_len(ri.a) + imm_len(ri.b) != 3'd0)
                    begin phase_next = PH_IMM; fidx_next = 2'd0; end
                    else fin = 1'b1;
                end
                else fidx_next = n[1:0];
            end
            PH_IMM:
            begin
                need     = imm_len(ri.a) + imm_len(ri.b);
                imm_next = imm_reg | shifted;
                cnt_next = cnt_inc;
                if (!ri.ok) begin emit = 1'b1; st = ST_UNKNOWN; end
                else if (n >= need) fin = 1'b1;
                else fidx_next = n[1:0];
            end
            default: phase_next = PH_START;
        endcase
        if (fin) emit = 1'b1;
    end

    // Operand formatting on the finishing state
    logic [2:0] ka, kb;
    logic [3:0] ra, rb;

    x86d_operand u_opa (
        .s(ri.a), .opcode(op_next), .modrm(mrm_next), .rex(rex_next),
        .mem_base(base_next), .kind(ka), .rnum(ra)
    );
    x86d_operand u_opb (
        .s(ri.b), .opcode(op_next), .modrm(mrm_next), .rex(rex_next),
        .mem_base(base_next), .kind(kb), .rnum(rb)
    );

    // Displacement/immediate fields of a finished instruction
    logic [1:0]  dsz;
    logic [31:0] dval;
    logic [31:0] ival;
    logic        a_mem, b_mem;

    assign a_mem = (ka == K_MEM);
    assign b_mem = (kb == K_MEM);

    always_comb
    begin
        dsz  = 2'd0;
        dval = 32'd0;
        ival = 32'd0;
        if (a_mem || b_mem)
        begin
            if (mrm_next[7:6] == 2'd1)
            begin
                dsz = 2'd1; dval = {{24{disp_next[7]}}, disp_next[7:0]};
            end
            else if (mrm_next[7:6] == 2'd2)
            begin
                dsz = 2'd2; dval = disp_next;
            end
        end
        if (ri.a == S_JB) dval = {{24{imm_next[7]}}, imm_next[7:0]};
        else if (ri.a == S_JZ) dval = imm_next;
        if (ka == K_IMM || kb == K_IMM) ival = imm_next;
    end

    // Parse state; restart after any result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            rex_reg   <= 5'd0;
            op_reg    <= 8'd0;
            mrm_reg   <= 8'd0;
            cnt_reg   <= 4'd0;
            fidx_reg  <= 2'd0;
            disp_reg  <= 32'd0;
            imm_reg   <= 32'd0;
            base_reg  <= 4'd0;
        end
        else if (accept)
        begin
            if (emit)
            begin
                phase_reg <= PH_START;
                rex_reg   <= 5'd0;
                op_reg    <= 8'd0;
                mrm_reg   <= 8'd0;
                cnt_reg   <= 4'd0;
                fidx_reg  <= 2'd0;
                disp_reg  <= 32'd0;
                imm_reg   <= 32'd0;
                base_reg  <= 4'd0;
            end
            else
            begin
                phase_reg <= phase_next;
                rex_reg   <= rex_next;
                op_reg    <= op_next;
                mrm_reg   <= mrm_next;
                cnt_reg   <= cnt_next;
                fidx_reg  <= fidx_next;
                disp_reg  <= disp_next;
                imm_reg   <= imm_next;
                base_reg  <= base_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) ov_reg <= 1'b0;
        else if (accept && emit) ov_reg <= 1'b1;
        else if (!out_stall) ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            opcode_byte <= op_next;
            length      <= cnt_next;
            status      <= st;
            mnemonic    <= fin ? ri.mn : 5'd0;
            first_kind  <= fin ? ka : K_NONE;
            first_reg   <= fin ? ra : 4'd0;
            second_kind <= fin ? kb : K_NONE;
            second_reg  <= fin ? rb : 4'd0;
            disp_size   <= fin ? dsz : 2'd0;
            disp_value  <= fin ? dval : 32'd0;
            imm_value   <= fin ? ival : 32'd0;
        end
    end

    assign out_valid = ov_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(length))
        else $error("result lost while stalled");
    a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while result stalled");
    a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> length != 4'd0)
        else $error("zero length result");
endmodule

>>> test/x86_64_subset_instruction_decoder_test.sv
// Self-checking testbench for the x86-64 subset decoder: directed and random byte streams,
// checked against a cycle-free decode predictor. Depends on x86d_pkg and the decoder RTL.
module x86_64_subset_instruction_decoder_test;
    import x86d_pkg::*;

    typedef struct packed {
        logic [7:0]  opc;
        logic [4:0]  mn;
        logic [3:0]  len;
        logic [2:0]  k1;
        logic [3:0]  r1;
        logic [2:0]  k2;
        logic [3:0]  r2;
        logic [1:0]  dsz;
        logic [31:0] dval;
        logic [31:0] imm;
        logic [1:0]  st;
    } insn_t;

    // parse phases of the predictor
    typedef enum logic [2:0] {P_START, P_OPC, P_MODRM, P_SIB, P_DISP, P_IMM} parse_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [7:0] code_byte;
    logic [7:0] opcode_byte;
    logic [4:0] mnemonic;
    logic [3:0] length;
    logic [2:0] first_kind, second_kind;
    logic [3:0] first_reg, second_reg;
    logic [1:0] disp_size, status;
    logic signed [31:0] disp_value;
    logic [31:0] imm_value;

    x86_64_subset_instruction_decoder u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .code_byte(code_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .opcode_byte(opcode_byte), .mnemonic(mnemonic), .length(length),
        .first_kind(first_kind), .first_reg(first_reg),
        .second_kind(second_kind), .second_reg(second_reg),
        .disp_size(disp_size), .disp_value(disp_value),
        .imm_value(imm_value), .status(status)
    );

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // predictor state
    parse_t      ph;
    logic [4:0]  rex;
    logic [7:0]  h_op, h_modrm;
    logic [3:0]  nbytes;
    logic [1:0]  fidx;
    logic [31:0] disp_acc, imm_acc;
    logic [3:0]  mbase;

    insn_t decoded_q[$];
    int    byte_q[$];          // -1 marks a pause until all results are in
    int    mismatches;
    bit    pausing;

    // opcode table
    function automatic void op_table(input logic [7:0] op, output bit known,
                                     output grp_t grp, output logic [4:0] mn,
                                     output spec_t a, output spec_t b);
        known = 1; grp = G_NONE; mn = 5'd0; a = S_NONE; b = S_NONE;
        if (op[7:3] == 5'h0a) begin mn = MN_PUSH; a = S_R64; end
        else if (op[7:3] == 5'h0b) begin mn = MN_POP; a = S_R64; end
        else if (op[7:3] == 5'h16) begin mn = MN_MOV; a = S_R8; b = S_IB; end
        else if (op[7:3] == 5'h17) begin mn = MN_MOV; a = S_R64; b = S_IV; end
        else
        begin
            case (op)
                8'h03: begin mn = MN_ADD; a = S_GV; b = S_EV; end
                8'h1b: begin mn = MN_SBB; a = S_GV; b = S_EV; end
                8'h24: begin mn = MN_AND; a = S_RAL; b = S_IB; end
                8'h33: begin mn = MN_XOR; a = S_GV; b = S_EV; end
                8'h74: begin mn = MN_JE; a = S_JB; end
                8'h75: begin mn = MN_JNE; a = S_JB; end
                8'h80: begin grp = G_ONE; a = S_EB; b = S_IB; end
                8'h81: begin grp = G_ONE; a = S_EV; b = S_IZ; end
                8'h83: begin grp = G_ONE; a = S_EV; b = S_IB; end
                8'h84: begin mn = MN_TEST; a = S_EB; b = S_GB; end
                8'h85: begin mn = MN_TEST; a = S_EV; b = S_GV; end
                8'h89: begin mn = MN_MOV; a = S_EV; b = S_GV; end
                8'h8b: begin mn = MN_MOV; a = S_GV; b = S_EV; end
                8'h8d: begin mn = MN_LEA; a = S_GV; b = S_M; end
                8'hc3: mn = MN_RET;
                8'hcc: mn = MN_INT3;
                8'he8: begin mn = MN_CALL; a = S_JZ; end
                8'he9: begin mn = MN_JMP; a = S_JZ; end
                8'heb: begin mn = MN_JMP; a = S_JB; end
                8'hf6: begin grp = G_THREE; a = S_EB; end
                8'hf7: begin grp = G_THREE; a = S_EV; end
                default: known = 0;
            endcase
        end
    endfunction

    // table lookup with groups 1 and 3 resolved by the ModR/M reg field
    function automatic void lookup_insn(input logic [7:0] op, input logic [7:0] modrm,
                                        output bit ok, output logic [4:0] mn,
                                        output spec_t a, output spec_t b);
        grp_t g;
        op_table(op, ok, g, mn, a, b);
        if (g == G_ONE) mn = {2'b00, modrm[5:3]};
        else if (g == G_THREE)
        begin
            if (modrm[5:3] == 3'd1) ok = 0;
            else if (modrm[5:3] == 3'd0)
            begin
                mn = MN_TEST;
                b = (op == 8'hf6) ? S_IB : S_IZ;
            end
            else mn = 5'd7 + {2'b00, modrm[5:3]};
        end
    endfunction

    function automatic int imm_bytes(input spec_t s);
        if (s == S_IB || s == S_JB) return 1;
        if (s == S_IV || s == S_IZ || s == S_JZ) return 4;
        return 0;
    endfunction

    function automatic bit takes_modrm(input spec_t s);
        return s == S_EB || s == S_EV || s == S_GB || s == S_GV || s == S_M;
    endfunction

    function automatic logic [31:0] sx8(input logic [31:0] x);
        return {{24{x[7]}}, x[7:0]};
    endfunction

    function automatic void clear_parse();
        ph = P_START; rex = '0; h_op = '0; h_modrm = '0; nbytes = '0; fidx = '0;
        disp_acc = '0; imm_acc = '0; mbase = '0;
    endfunction

    function automatic insn_t fault(input logic [1:0] st);
        insn_t r;
        r = '0; r.opc = h_op; r.len = nbytes; r.st = st;
        clear_parse();
        return r;
    endfunction

    // fill one operand slot
    function automatic void place(input spec_t s, inout insn_t r, input bit second);
        logic [2:0] kd;
        logic [3:0] rg;
        logic [3:0] bx, rx;
        kd = K_NONE; rg = '0;
        bx = rex[0] ? 4'd8 : 4'd0;
        rx = rex[2] ? 4'd8 : 4'd0;
        case (s)
            S_EB, S_EV, S_M:
                if (h_modrm[7:6] == 2'd3)
                begin
                    rg = {1'b0, h_modrm[2:0]} | bx;
                    if (s == S_EV) kd = rex[3] ? K_REG64 : K_REG32;
                    else kd = rex[4] ? K_REG8X : K_REG8;
                end
                else
                begin
                    kd = K_MEM; rg = mbase;
                    if (h_modrm[7:6] == 2'd1) begin r.dsz = 2'd1; r.dval = sx8(disp_acc); end
                    else if (h_modrm[7:6] == 2'd2) begin r.dsz = 2'd2; r.dval = disp_acc; end
                end
            S_GB: begin kd = rex[4] ? K_REG8X : K_REG8; rg = {1'b0, h_modrm[5:3]} | rx; end
            S_GV: begin kd = rex[3] ? K_REG64 : K_REG32; rg = {1'b0, h_modrm[5:3]} | rx; end
            S_IB, S_IV, S_IZ: begin kd = K_IMM; r.imm = imm_acc; end
            S_JB: begin kd = K_REL; r.dval = sx8(imm_acc); end
            S_JZ: begin kd = K_REL; r.dval = imm_acc; end
            S_R8: begin kd = rex[4] ? K_REG8X : K_REG8; rg = {1'b0, h_op[2:0]} | bx; end
            S_R64: begin kd = K_REG64; rg = {1'b0, h_op[2:0]} | bx; end
            S_RAL: kd = K_REG8;
            default: ;
        endcase
        if (second) begin r.k2 = kd; r.r2 = rg; end
        else begin r.k1 = kd; r.r1 = rg; end
    endfunction

    function automatic bit complete(output insn_t r);
        bit ok;
        logic [4:0] mn;
        spec_t a, b;
        lookup_insn(h_op, h_modrm, ok, mn, a, b);
        if (!ok) begin r = fault(ST_UNKNOWN); return 1; end
        r = '0; r.opc = h_op; r.mn = mn; r.len = nbytes; r.st = ST_OK;
        place(a, r, 0);
        place(b, r, 1);
        clear_parse();
        return 1;
    endfunction

    function automatic bit enter_imm(output insn_t r);
        bit ok;
        logic [4:0] mn;
        spec_t a, b;
        lookup_insn(h_op, h_modrm, ok, mn, a, b);
        if (!ok) begin r = fault(ST_UNKNOWN); return 1; end
        if (imm_bytes(a) + imm_bytes(b) != 0) begin ph = P_IMM; fidx = 2'd0; return 0; end
        return complete(r);
    endfunction

    function automatic bit after_address(output insn_t r);
        if (h_modrm[7:6] == 2'd1 || h_modrm[7:6] == 2'd2)
        begin
            ph = P_DISP; fidx = 2'd0; return 0;
        end
        return enter_imm(r);
    endfunction

    function automatic bit take_opcode(input logic [7:0] b, output insn_t r);
        bit known;
        grp_t g;
        logic [4:0] mn;
        spec_t a, s1;
        h_op = b; nbytes = nbytes + 4'd1;
        op_table(b, known, g, mn, a, s1);
        if (!known) begin r = fault(ST_UNKNOWN); return 1; end
        if ((a == S_R8 || a == S_R64) && rex[3:1] != 3'd0)
        begin
            r = fault(ST_UNSUP); return 1;
        end
        if (s1 == S_IV && rex != 5'd0) begin r = fault(ST_UNSUP); return 1; end
        if (takes_modrm(a) || takes_modrm(s1)) begin ph = P_MODRM; return 0; end
        return enter_imm(r);
    endfunction

    // advance the predictor by one code byte; returns 1 when a result is due
    function automatic bit decode_byte(input logic [7:0] b, output insn_t r);
        bit ok;
        logic [4:0] mn;
        spec_t a, s1;
        int need;
        logic [3:0] bx;
        bx = rex[0] ? 4'd8 : 4'd0;
        r = '0;
        case (ph)
            P_START:
                if (b[7:4] == 4'h4)
                begin
                    rex = {1'b1, b[3:0]}; nbytes = 4'd1; ph = P_OPC; return 0;
                end
                else return take_opcode(b, r);
            P_OPC: return take_opcode(b, r);
            P_MODRM:
            begin
                h_modrm = b; nbytes = nbytes + 4'd1;
                lookup_insn(h_op, h_modrm, ok, mn, a, s1);
                if (!ok) begin r = fault(ST_UNKNOWN); return 1; end
                if (b[7:6] == 2'd3)
                begin
                    if (a == S_M || s1 == S_M) begin r = fault(ST_UNSUP); return 1; end
                    return enter_imm(r);
                end
                if (b[2:0] == 3'd4) begin ph = P_SIB; return 0; end
                mbase = {1'b0, b[2:0]} | bx;
                return after_address(r);
            end
            P_SIB:
            begin
                nbytes = nbytes + 4'd1;
                if (b[5:3] != 3'd4) begin r = fault(ST_UNSUP); return 1; end
                mbase = {1'b0, b[2:0]} | bx;
                return after_address(r);
            end
            P_DISP:
            begin
                need = (h_modrm[7:6] == 2'd1) ? 1 : 4;
                disp_acc = disp_acc | ({24'd0, b} << (8 * fidx));
                nbytes = nbytes + 4'd1;
                if (fidx + 1 >= need) return enter_imm(r);
                fidx = fidx + 2'd1;
                return 0;
            end
            default:
            begin
                lookup_insn(h_op, h_modrm, ok, mn, a, s1);
                if (!ok) begin r = fault(ST_UNKNOWN); return 1; end
                need = imm_bytes(a) + imm_bytes(s1);
                imm_acc = imm_acc | ({24'd0, b} << (8 * fidx));
                nbytes = nbytes + 4'd1;
                if (fidx + 1 >= need) return complete(r);
                fidx = fidx + 2'd1;
                return 0;
            end
        endcase
    endfunction

    // stimulus builders
    task automatic put(input int b);
        byte_q.push_back(b);
    endtask

    task automatic put_bytes(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) put(int'((v >> (8 * i)) & 32'hff));
    endtask

    // one mostly well-formed instruction with random content
    task automatic gen_insn();
        logic [7:0] ops[29] = '{8'h50, 8'h58, 8'hb0, 8'hb8, 8'h03, 8'h1b, 8'h24, 8'h33,
            8'h74, 8'h75, 8'h80, 8'h81, 8'h83, 8'h84, 8'h85, 8'h89, 8'h8b, 8'h8d, 8'hc3,
            8'hcc, 8'he8, 8'he9, 8'heb, 8'hf6, 8'hf7, 8'h57, 8'h5f, 8'hb7, 8'hbf};
        logic [7:0] op, modrm, rexb;
        bit ok, known;
        grp_t g;
        logic [4:0] mn;
        spec_t a, b;
        op = ops[$urandom_range(0, 28)];
        if (op[7:3] == 5'h0a || op[7:3] == 5'h0b || op[7:3] == 5'h16) op[2:0] = 3'($urandom);
        if (op[7:3] == 5'h17) op[2:0] = 3'($urandom);
        op_table(op, known, g, mn, a, b);
        if ($urandom_range(0, 2) == 0)
        begin
            rexb = 8'h40 | 8'($urandom & 32'h0f);
            // keep most register-in-opcode forms legal
            if ((a == S_R8 || a == S_R64) && $urandom_range(0, 3) != 0) rexb[3:1] = 3'd0;
            if (b == S_IV && $urandom_range(0, 3) != 0) rexb = 8'h00;
            if (rexb != 8'h00) put(rexb);
        end
        put(op);
        modrm = 8'($urandom);
        if (takes_modrm(a) || takes_modrm(b))
        begin
            if (op == 8'h8d && modrm[7:6] == 2'd3 && $urandom_range(0, 3) != 0)
                modrm[7:6] = 2'd0;
            if ((op == 8'hf6 || op == 8'hf7) && modrm[5:3] == 3'd1 && $urandom_range(0, 1))
                modrm[5:3] = 3'd0;
            put(modrm);
            if (modrm[7:6] != 2'd3 && modrm[2:0] == 3'd4)
                put($urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                              : ({2'($urandom_range(0, 3)), 3'd4, 3'd0} |
                                                 3'($urandom_range(0, 7))));
            if (modrm[7:6] == 2'd1) put($urandom_range(0, 255));
            if (modrm[7:6] == 2'd2) put_bytes($urandom, 4);
        end
        lookup_insn(op, modrm, ok, mn, a, b);
        if (ok) put_bytes($urandom, imm_bytes(a) + imm_bytes(b));
    endtask

    // input side: gaps drawn per word, bursts without gaps now and then
    int in_gap;
    bit in_burst;
    always @(posedge clk or negedge rst_n)
    begin
        insn_t r;
        bit busy, nv;
        if (!rst_n)
        begin
            in_valid <= 1'b0; code_byte <= 8'h00; in_gap = 0; in_burst = 0; pausing = 0;
            clear_parse();
        end
        else
        begin
            busy = in_valid && in_stall;
            if (in_valid && !in_stall)
                if (decode_byte(code_byte, r)) decoded_q.push_back(r);
            nv = busy;
            if (!busy)
            begin
                if (pausing && decoded_q.size() == 0) pausing = 0;
                if (byte_q.size() > 0 && byte_q[0] < 0 && !pausing)
                begin
                    void'(byte_q.pop_front());
                    pausing = 1;
                end
                else if (in_gap > 0) in_gap--;
                else if (!pausing && byte_q.size() > 0)
                begin
                    code_byte <= 8'(byte_q.pop_front());
                    nv = 1;
                    if ($urandom_range(0, 40) == 0) in_burst = !in_burst;
                    in_gap = in_burst ? 0 : int'($urandom_range(0, 15));
                end
            end
            in_valid <= nv;
        end
    end

    // output side: stall drawn per word, checked against oldest prediction
    int out_hold;
    bit out_burst;
    always @(posedge clk or negedge rst_n)
    begin
        insn_t got, want;
        if (!rst_n)
        begin
            out_stall <= 1'b0; out_hold = 0; out_burst = 0; mismatches = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{opcode_byte, mnemonic, length, first_kind, first_reg, second_kind,
                        second_reg, disp_size, disp_value, imm_value, status};
                if (decoded_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word: %p", got);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (got.opc !== want.opc || got.mn !== want.mn || got.len !== want.len ||
                        got.k1 !== want.k1 || got.r1 !== want.r1 || got.k2 !== want.k2 ||
                        got.r2 !== want.r2 || got.dsz !== want.dsz ||
                        got.dval !== want.dval || got.imm !== want.imm || got.st !== want.st)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
                if ($urandom_range(0, 30) == 0) out_burst = !out_burst;
                out_hold = out_burst ? 0 : int'($urandom_range(0, 15));
            end
            if (out_hold > 0)
            begin
                out_hold--;
                out_stall <= 1'b1;
            end
            else out_stall <= 1'b0;
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        // directed: extremes, every opcode class, faults
        put(8'h50); put(8'h41); put(8'h57); put(8'h41); put(8'h5f);
        put(8'h48); put(8'h03); put(8'hc1);                      // add r64, r64
        put(8'h8d); put(8'hc0);                                  // lea with register
        put(8'h48); put(8'hb8);                                  // mov r64 imm under REX
        put(8'h4c); put(8'h50);                                  // push with REX.R
        put(8'h8b); put(8'h04); put(8'h00);                      // SIB index not 4
        put(8'h8b); put(8'h04); put(8'h24);
        put(8'h0f); put(8'hff);                                  // unknown opcodes
        put(8'h40); put(8'h41);                                  // second REX
        put(8'hf6); put(8'hc8);                                  // group 3 reg 1
        put(8'h41); put(8'hf6); put(8'hc0); put(8'h7f);          // test r8, ib
        put(8'h48); put(8'hf7); put(8'h04); put(8'h24); put_bytes(32'hffffffff, 4);
        put(8'h4f); put(8'h81); put(8'hbc); put(8'h24); put_bytes(32'h80000000, 4);
        put_bytes(32'h00000000, 4);                              // longest form
        put(8'h8b); put(8'h45); put(8'h80);                      // disp8 negative
        put(8'h89); put(8'h85); put_bytes(32'h7fffffff, 4);
        put(8'h74); put(8'h80); put(8'h75); put(8'h7f); put(8'heb); put(8'hff);
        put(8'he8); put_bytes(32'h80000000, 4); put(8'he9); put_bytes(32'h1, 4);
        put(8'hc3); put(8'hcc); put(8'h24); put(8'hff);
        put(8'h41); put(8'hb7); put(8'h55); put(8'hb0); put(8'h00);
        put(8'hbb); put_bytes(32'hdeadbeef, 4);
        put(8'h40); put(8'h84); put(8'hf6); put(8'h1b); put(8'h05); put(8'h33); put(8'h3c);
        put(8'h64);
        put(8'h83); put(8'h45); put(8'h00); put(8'h01);
        put(-1);
        // random: mostly instructions, some noise
        for (int i = 0; i < 75; i++)
        begin
            if ($urandom_range(0, 9) == 0) put($urandom_range(0, 255));
            else gen_insn();
            if (i == 40) put(-1);
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // drained when nothing is queued, nothing is offered and no result is owed
        do @(negedge clk);
        while (byte_q.size() != 0 || in_valid || decoded_q.size() != 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && decoded_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
